// ===== rtl/wgm_pkg.sv =====
// wgm_pkg: shared types, command codes and code-unit helpers for the
// wildcard glob matcher. No dependencies; used by wgm_cell and the top level.
`default_nettype none

package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int UNIT_W          = 16;

    localparam logic [UNIT_W-1:0] UNIT_STAR     = 16'h002A;
    localparam logic [UNIT_W-1:0] UNIT_QUESTION = 16'h003F;
    localparam logic [UNIT_W-1:0] UNIT_UPPER_A  = 16'h0041;
    localparam logic [UNIT_W-1:0] UNIT_UPPER_Z  = 16'h005A;
    localparam logic [UNIT_W-1:0] CASE_OFFSET   = 16'h0020;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // Per-cell control driven by the top level each cycle.
    typedef struct packed {
        logic in_use;   // position lies inside the stored pattern
        logic at_tail;  // position equals the pattern length
        logic write;    // load this cell with the appended unit
        logic rearm;    // reset the active set to the start position
        logic step;     // advance the active set by one text unit
    } cell_ctl_t;

    // Fold ASCII upper case to lower case; leave every other unit alone.
    function automatic logic [UNIT_W-1:0] fold_unit(input logic [UNIT_W-1:0] u);
        logic [UNIT_W-1:0] r;
        r = u;
        if ((u >= UNIT_UPPER_A) && (u <= UNIT_UPPER_Z))
        begin
            r = u + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wildcard_glob_matcher.sv =====
// wildcard_glob_matcher: top level of the streaming glob matcher.
// Instantiates a row of wgm_cell positions; depends on wgm_pkg.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready, command, code_unit) takes one word
//   per cycle: clear pattern, append pattern unit, text unit, end of text.
//   '*' matches any run (also empty), '?' one unit, other units compare
//   after folding ASCII A-Z to lower case. Units past MAX_PATTERN are
//   dropped and flagged in pattern_overflow until the next clear.
//   Result channel (res_valid/res_ready, matched, pattern_overflow) carries
//   one word per end-of-text command, in the cycle after it is accepted.
//   Throughput is one command word per cycle. Each text unit updates every
//   position at once; the star closure ripples along the cell row in the
//   same cycle, so the row length sets the critical path.
//   The result register frees as it is read: while a result waits and
//   res_ready is low, cmd_ready drops; otherwise commands keep flowing.
//   Clear, append and end of text rearm the matcher to the start position.
//   Reset: pattern empty, overflow clear, only the start position active,
//   no result pending. Pattern storage itself is not reset.
`default_nettype none

module wildcard_glob_matcher #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cmd_valid,
    output logic                       cmd_ready,
    input  wire [1:0]                  command,
    input  wire [wgm_pkg::UNIT_W-1:0]  code_unit,
    output logic                       res_valid,
    input  wire                        res_ready,
    output logic                       matched,
    output logic                       pattern_overflow
);
    import wgm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    cmd_t              cmd;
    logic              accept;
    logic              is_clear;
    logic              is_append;
    logic              is_text;
    logic              is_end;
    logic              full;
    logic              rearm;
    logic [UNIT_W-1:0] folded_unit;

    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic              end_active_reg;
    logic              end_active_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              matched_reg;
    logic              pattern_overflow_reg;

    logic [MAX_PATTERN:0]   chain;
    logic [MAX_PATTERN:0]   match;
    logic [MAX_PATTERN-1:0] cell_hit;
    logic                   end_hit;
    logic                   hit;

    // Decode the accepted word.
    assign cmd         = cmd_t'(command);
    assign accept      = cmd_valid & cmd_ready;
    assign is_clear    = accept & (cmd == CMD_CLEAR);
    assign is_append   = accept & (cmd == CMD_APPEND);
    assign is_text     = accept & (cmd == CMD_TEXT);
    assign is_end      = accept & (cmd == CMD_END);
    assign rearm       = is_clear | is_append | is_end;
    assign full        = (length_reg == LEN_W'(MAX_PATTERN));
    assign folded_unit = fold_unit(code_unit);

    // Hold off new words only while a result is stuck in the output register.
    assign cmd_ready = ~res_valid_reg | res_ready;

    assign chain[0] = 1'b0;
    assign match[0] = 1'b0;

    // The cell row: position i hands its star closure and its match to i+1.
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        cell_ctl_t ctl;

        always_comb
        begin
            ctl.in_use  = (LEN_W'(i) < length_reg);
            ctl.at_tail = (LEN_W'(i) == length_reg);
            ctl.write   = is_append & ~full & (LEN_W'(i) == length_reg);
            ctl.rearm   = rearm;
            ctl.step    = is_text;
        end

        wgm_cell #(
            .HOME (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_unit   (folded_unit),
            .text_unit (folded_unit),
            .chain_in  (chain[i]),
            .match_in  (match[i]),
            .chain_out (chain[i+1]),
            .match_out (match[i+1]),
            .hit       (cell_hit[i])
        );
    end

    // Final position past the last pattern slot: reached only by a full pattern.
    assign end_hit = (end_active_reg | chain[MAX_PATTERN]) & full;
    assign hit     = (|cell_hit) | end_hit;

    always_comb
    begin
        length_next     = length_reg;
        overflow_next   = overflow_reg;
        end_active_next = end_active_reg;
        res_valid_next  = res_valid_reg;

        priority if (is_clear)
        begin
            length_next   = '0;
            overflow_next = 1'b0;
        end
        else if (is_append)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                length_next = length_reg + LEN_W'(1);
            end
        end
        else
        begin
            length_next = length_reg;
        end

        priority if (rearm)
        begin
            end_active_next = 1'b0;
        end
        else if (is_text)
        begin
            end_active_next = match[MAX_PATTERN];
        end
        else
        begin
            end_active_next = end_active_reg;
        end

        // Load on end of text, drop once the receiver takes it.
        priority if (is_end)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg     <= '0;
            overflow_reg   <= 1'b0;
            end_active_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            length_reg     <= length_next;
            overflow_reg   <= overflow_next;
            end_active_reg <= end_active_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Result payload: capture the verdict and the flag as the end word lands.
    always_ff @(posedge clk)
    begin
        if (is_end)
        begin
            matched_reg          <= hit;
            pattern_overflow_reg <= overflow_reg;
        end
    end

    assign res_valid        = res_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = pattern_overflow_reg;

    a_length_bound : assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length past capacity");

    a_end_loads_result : assert property (@(posedge clk) disable iff (!rst_n)
        is_end |=> res_valid_reg)
        else $error("end of text did not load a result");

    a_overflow_on_full : assert property (@(posedge clk) disable iff (!rst_n)
        (is_append && full) |=> (overflow_reg && $stable(length_reg)))
        else $error("append to full pattern not flagged");

    a_rearm_clears_end : assert property (@(posedge clk) disable iff (!rst_n)
        rearm |=> !end_active_reg)
        else $error("final position survived a rearm");

    a_no_accept_when_stuck : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |-> !accept)
        else $error("word accepted over a pending result");

endmodule

`default_nettype wire

// ===== rtl/wgm_cell.sv =====
// wgm_cell: one pattern position of the matcher chain. Holds the folded
// pattern unit and the active bit. Depends on wgm_pkg.
`default_nettype none

module wgm_cell #(
    parameter bit HOME = 1'b0
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wgm_pkg::cell_ctl_t         ctl,
    input  wire [wgm_pkg::UNIT_W-1:0]  wr_unit,
    input  wire [wgm_pkg::UNIT_W-1:0]  text_unit,
    input  wire                        chain_in,
    input  wire                        match_in,
    output logic                       chain_out,
    output logic                       match_out,
    output logic                       hit
);
    import wgm_pkg::*;

    logic [UNIT_W-1:0] unit_reg;
    logic              star_reg;
    logic              any_reg;
    logic              active_reg;
    logic              active_next;
    logic              closed;

    // Payload: folded unit plus decoded wildcard flags.
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            unit_reg <= wr_unit;
            star_reg <= (wr_unit == UNIT_STAR);
            any_reg  <= (wr_unit == UNIT_QUESTION);
        end
    end

    // Active position, closed over any star run reaching in from the left.
    assign closed    = active_reg | chain_in;
    assign chain_out = closed & ctl.in_use & star_reg;
    assign match_out = closed & ctl.in_use & ~star_reg
                     & (any_reg | (unit_reg == text_unit));
    assign hit       = closed & ctl.at_tail;

    always_comb
    begin
        active_next = active_reg;
        priority if (ctl.rearm)
        begin
            active_next = HOME;
        end
        else if (ctl.step)
        begin
            // A star keeps itself alive; a matching left neighbor advances here.
            active_next = chain_out | match_in;
        end
        else
        begin
            active_next = active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= HOME;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire
